[hdl/sbmi_pkg.sv]
// Shared widths, types and tuser bit positions for the small block matrix inverse.
// No dependencies; every other file in hdl/ uses it by scoped names.
`timescale 1ns / 1ps

package sbmi_pkg;

   localparam int WORD_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int DIM     = 3;
   localparam int NENT    = DIM * DIM;
   localparam int BS_W    = 2;
   localparam int PROD_W  = 2 * WORD_W;
   localparam int COF_W   = PROD_W + 1;
   localparam int DET_W   = WORD_W + COF_W;
   localparam int CMAG_W  = PROD_W;
   localparam int DMAG_W  = DET_W - 1;
   localparam int SHIFT_W = 2 * FRAC_W + 1;
   localparam int NUM_W   = CMAG_W + SHIFT_W + 1;
   localparam int DEN_W   = DMAG_W + 1;
   localparam int QUO_W   = WORD_W + 2;
   localparam int CMP_W   = DEN_W + QUO_W - 1;
   localparam int DATA_W  = NENT * WORD_W;
   localparam int USER_W  = 2;

   localparam int USER_SING = 0;
   localparam int USER_SAT  = 1;

   localparam logic [BS_W-1:0] BS_ZERO = 2'd0;
   localparam logic [BS_W-1:0] BS_ONE  = 2'd1;
   localparam logic [BS_W-1:0] BS_TWO  = 2'd2;
   localparam logic [BS_W-1:0] BS_FULL = 2'd3;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [COF_W-1:0]  cof_type;
   typedef logic signed [DET_W-1:0]  det_type;

   typedef struct packed {
      logic              vld;
      logic              sing;
      logic              sat;
      logic [WORD_W-1:0] val;
   } lane_res_type;

endpackage

[hdl/small_block_matrix_inverse.sv]
// Small block matrix inverse (size 1, 2 or 3) by adjugate over determinant.
// Depends on sbmi_pkg, sbmi_cofactor, sbmi_det, sbmi_div_lane and sbmi_merge.
//
// Usage:
//   req channel: one transfer carries a block of nine signed Q16.16 entries in
//   column-major order. rsp channel: one transfer per block with the nine inverse
//   entries in the same order and format, plus singular and saturated flags in tuser.
//   csr_we/csr_wdata write block_size (0 acts as 1); write only while the block is idle.
// Throughput: one block per cycle while req_tready is high. Nine divider lanes run
//   side by side, each a 34-stage restoring divider retiring one quotient bit per stage.
// Reset: synchronous; clears all valid bits, block_size returns to 1.
// Stall: an output register plus a skid register; when rsp_tready is low one more
//   result is absorbed, then the whole pipeline holds and req_tready drops until the
//   skid register drains.
`timescale 1ns / 1ps

module small_block_matrix_inverse (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [sbmi_pkg::BS_W-1:0]     csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // e11 e21 e31 e12 e22 e32 e13 e23 e33, 32 bits each, from bit 0
   input  logic [sbmi_pkg::DATA_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // r11 r21 r31 r12 r22 r32 r13 r23 r33, 32 bits each, from bit 0
   output logic [sbmi_pkg::DATA_W-1:0]   rsp_tdata,
   // singular, saturated, from bit 0
   output logic [sbmi_pkg::USER_W-1:0]   rsp_tuser
);

   logic                           adv;
   logic [sbmi_pkg::BS_W-1:0]      block_size_ff;
   sbmi_pkg::word_type             ent_ff[sbmi_pkg::NENT];
   logic                           v0_ff;
   sbmi_pkg::cof_type              cf_c[sbmi_pkg::NENT];
   sbmi_pkg::word_type             row0_c[sbmi_pkg::DIM];
   logic                           vld_c;
   sbmi_pkg::cof_type              cf_d[sbmi_pkg::NENT];
   sbmi_pkg::det_type              det_d;
   logic                           vld_d;
   sbmi_pkg::lane_res_type         lane_res[sbmi_pkg::NENT];

   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= sbmi_pkg::BS_ONE;
      end else if (csr_we) begin
         block_size_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && req_tvalid) begin
         for (int i = 0; i < sbmi_pkg::NENT; i++) begin
            ent_ff[i] <= req_tdata[i*sbmi_pkg::WORD_W +: sbmi_pkg::WORD_W];
         end
      end
   end

   sbmi_cofactor u_cofactor (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_vld     (v0_ff),
      .block_size (block_size_ff),
      .ent        (ent_ff),
      .cf         (cf_c),
      .row0       (row0_c),
      .out_vld    (vld_c)
   );

   sbmi_det u_det (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (vld_c),
      .cf      (cf_c),
      .row0    (row0_c),
      .cf_o    (cf_d),
      .det     (det_d),
      .out_vld (vld_d)
   );

   for (genvar o = 0; o < sbmi_pkg::NENT; o++) begin : g_lane
      sbmi_div_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .in_vld (vld_d),
         .cf     (cf_d[o]),
         .det    (det_d),
         .res    (lane_res[o])
      );
   end

   sbmi_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .res        (lane_res),
      .adv        (adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[hdl/sbmi_cofactor.sv]
// Cofactor stage: selects multiplier operands per block size, forms 18 products, then
// the nine cofactors. Depends on sbmi_pkg.
`timescale 1ns / 1ps

module sbmi_cofactor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_vld,
   input  logic [sbmi_pkg::BS_W-1:0]   block_size,
   input  sbmi_pkg::word_type          ent[sbmi_pkg::NENT],
   output sbmi_pkg::cof_type           cf[sbmi_pkg::NENT],
   output sbmi_pkg::word_type          row0[sbmi_pkg::DIM],
   output logic                        out_vld
);

   localparam sbmi_pkg::word_type ONE = sbmi_pkg::word_type'(1);

   logic [sbmi_pkg::BS_W-1:0] dim_n;
   sbmi_pkg::prod_type        pab_ff[sbmi_pkg::NENT];
   sbmi_pkg::prod_type        pcd_ff[sbmi_pkg::NENT];
   sbmi_pkg::cof_type         cf_ff[sbmi_pkg::NENT];
   sbmi_pkg::word_type        row0_s1_ff[sbmi_pkg::DIM];
   sbmi_pkg::word_type        row0_ff[sbmi_pkg::DIM];
   logic                      v1_ff;
   logic                      v2_ff;

   assign dim_n = (block_size == sbmi_pkg::BS_ZERO) ? sbmi_pkg::BS_ONE : block_size;

   for (genvar r = 0; r < sbmi_pkg::DIM; r++) begin : g_row
      for (genvar c = 0; c < sbmi_pkg::DIM; c++) begin : g_col
         localparam int I  = r * sbmi_pkg::DIM + c;
         localparam int R1 = (r + 1) % sbmi_pkg::DIM;
         localparam int R2 = (r + 2) % sbmi_pkg::DIM;
         localparam int C1 = (c + 1) % sbmi_pkg::DIM;
         localparam int C2 = (c + 2) % sbmi_pkg::DIM;
         sbmi_pkg::word_type opa, opb, opc, opd;

         always_comb begin
            opa = '0;
            opb = '0;
            opc = '0;
            opd = '0;
            case (dim_n)
               sbmi_pkg::BS_FULL: begin
                  opa = ent[C1 * sbmi_pkg::DIM + R1];
                  opb = ent[C2 * sbmi_pkg::DIM + R2];
                  opc = ent[C2 * sbmi_pkg::DIM + R1];
                  opd = ent[C1 * sbmi_pkg::DIM + R2];
               end
               sbmi_pkg::BS_TWO: begin
                  if (r == 0 && c == 0) begin
                     opa = ent[sbmi_pkg::DIM + 1];
                     opb = ONE;
                  end else if (r == 0 && c == 1) begin
                     opc = ent[1];
                     opd = ONE;
                  end else if (r == 1 && c == 0) begin
                     opc = ent[sbmi_pkg::DIM];
                     opd = ONE;
                  end else if (r == 1 && c == 1) begin
                     opa = ent[0];
                     opb = ONE;
                  end
               end
               default: begin
                  if (r == 0 && c == 0) begin
                     opa = ONE;
                     opb = ONE;
                  end
               end
            endcase
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               pab_ff[I] <= opa * opb;
               pcd_ff[I] <= opc * opd;
               cf_ff[I]  <= sbmi_pkg::COF_W'(pab_ff[I]) - sbmi_pkg::COF_W'(pcd_ff[I]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < sbmi_pkg::DIM; c++) begin
            row0_s1_ff[c] <= ent[c * sbmi_pkg::DIM];
            row0_ff[c]    <= row0_s1_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_vld;
         v2_ff <= v1_ff;
      end
   end

   assign cf      = cf_ff;
   assign row0    = row0_ff;
   assign out_vld = v2_ff;

endmodule

[hdl/sbmi_det.sv]
// Determinant stage: expands along the first row with split 32x33 products over three
// registered steps and carries the cofactors alongside. Depends on sbmi_pkg.
`timescale 1ns / 1ps

module sbmi_det (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  sbmi_pkg::cof_type     cf[sbmi_pkg::NENT],
   input  sbmi_pkg::word_type    row0[sbmi_pkg::DIM],
   output sbmi_pkg::cof_type     cf_o[sbmi_pkg::NENT],
   output sbmi_pkg::det_type     det,
   output logic                  out_vld
);

   localparam int PP_W = sbmi_pkg::WORD_W + sbmi_pkg::WORD_W + 1;

   logic signed [PP_W-1:0] plo_ff[sbmi_pkg::DIM];
   logic signed [PP_W-1:0] phi_ff[sbmi_pkg::DIM];
   sbmi_pkg::det_type      term_ff[sbmi_pkg::DIM];
   sbmi_pkg::det_type      det_ff;
   sbmi_pkg::cof_type      cf3_ff[sbmi_pkg::NENT];
   sbmi_pkg::cof_type      cf4_ff[sbmi_pkg::NENT];
   sbmi_pkg::cof_type      cf5_ff[sbmi_pkg::NENT];
   logic                   v3_ff;
   logic                   v4_ff;
   logic                   v5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < sbmi_pkg::DIM; c++) begin
            plo_ff[c]  <= row0[c] * $signed({1'b0, cf[c][sbmi_pkg::WORD_W-1:0]});
            phi_ff[c]  <= row0[c] * $signed(cf[c][sbmi_pkg::COF_W-1:sbmi_pkg::WORD_W]);
            term_ff[c] <= (sbmi_pkg::DET_W'(phi_ff[c]) <<< sbmi_pkg::WORD_W)
                          + sbmi_pkg::DET_W'(plo_ff[c]);
         end
         det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
         cf3_ff <= cf;
         cf4_ff <= cf3_ff;
         cf5_ff <= cf4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= in_vld;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   assign cf_o    = cf5_ff;
   assign det     = det_ff;
   assign out_vld = v5_ff;

endmodule

[hdl/sbmi_div_lane.sv]
// One output lane: rounded quotient cofactor * 2^(2F) / det by a pipelined restoring
// divider, one quotient bit per stage, then sign and saturation. Depends on sbmi_pkg.
`timescale 1ns / 1ps

module sbmi_div_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_vld,
   input  sbmi_pkg::cof_type      cf,
   input  sbmi_pkg::det_type      det,
   output sbmi_pkg::lane_res_type res
);

   localparam int LAST = sbmi_pkg::QUO_W - 1;

   sbmi_pkg::cof_type             cf_abs;
   sbmi_pkg::det_type             det_abs;
   logic [sbmi_pkg::NUM_W-1:0]    num0_ff;
   logic [sbmi_pkg::DEN_W-1:0]    den0_ff;
   logic                          neg0_ff;
   logic                          sing0_ff;
   logic                          v0_ff;
   logic [sbmi_pkg::NUM_W-1:0]    rem_ff[sbmi_pkg::QUO_W];
   logic [sbmi_pkg::DEN_W-1:0]    den_ff[sbmi_pkg::QUO_W];
   logic [sbmi_pkg::QUO_W-1:0]    q_ff[sbmi_pkg::QUO_W];
   logic                          neg_ff[sbmi_pkg::QUO_W];
   logic                          sing_ff[sbmi_pkg::QUO_W];
   logic                          vld_ff[sbmi_pkg::QUO_W];
   logic                          neg_eff;
   logic [sbmi_pkg::QUO_W-1:0]    lim;
   logic [sbmi_pkg::QUO_W-1:0]    mag;
   sbmi_pkg::lane_res_type        res_in;
   sbmi_pkg::lane_res_type        res_ff;

   assign cf_abs  = cf[sbmi_pkg::COF_W-1] ? -cf : cf;
   assign det_abs = det[sbmi_pkg::DET_W-1] ? -det : det;

   always_ff @(posedge clock) begin
      if (adv) begin
         num0_ff  <= sbmi_pkg::NUM_W'({cf_abs[sbmi_pkg::CMAG_W-1:0], {sbmi_pkg::SHIFT_W{1'b0}}})
                     + sbmi_pkg::NUM_W'(det_abs[sbmi_pkg::DMAG_W-1:0]);
         den0_ff  <= {det_abs[sbmi_pkg::DMAG_W-1:0], 1'b0};
         neg0_ff  <= cf[sbmi_pkg::COF_W-1] ^ det[sbmi_pkg::DET_W-1];
         sing0_ff <= (det == '0);
      end
   end

   for (genvar i = 0; i < sbmi_pkg::QUO_W; i++) begin : g_step
      localparam int K = sbmi_pkg::QUO_W - 1 - i;
      logic [sbmi_pkg::NUM_W-1:0] rem_s;
      logic [sbmi_pkg::DEN_W-1:0] den_s;
      logic [sbmi_pkg::QUO_W-1:0] q_s;
      logic                       neg_s, sing_s, vld_s;
      logic [sbmi_pkg::CMP_W-1:0] dsh, rx;
      logic                       ge;

      if (i == 0) begin : g_first
         assign rem_s  = num0_ff;
         assign den_s  = den0_ff;
         assign q_s    = '0;
         assign neg_s  = neg0_ff;
         assign sing_s = sing0_ff;
         assign vld_s  = v0_ff;
      end else begin : g_next
         assign rem_s  = rem_ff[i-1];
         assign den_s  = den_ff[i-1];
         assign q_s    = q_ff[i-1];
         assign neg_s  = neg_ff[i-1];
         assign sing_s = sing_ff[i-1];
         assign vld_s  = vld_ff[i-1];
      end

      assign dsh = sbmi_pkg::CMP_W'(den_s) << K;
      assign rx  = sbmi_pkg::CMP_W'(rem_s);
      assign ge  = (rx >= dsh);

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i]  <= ge ? sbmi_pkg::NUM_W'(rx - dsh) : rem_s;
            den_ff[i]  <= den_s;
            q_ff[i]    <= q_s | (ge ? (sbmi_pkg::QUO_W'(1) << K) : '0);
            neg_ff[i]  <= neg_s;
            sing_ff[i] <= sing_s;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_s;
         end
      end
   end

   // round-half-away already folded in; clip to the signed word range
   always_comb begin
      neg_eff = neg_ff[LAST] && (q_ff[LAST] != '0);
      lim     = (sbmi_pkg::QUO_W'(1) << (sbmi_pkg::WORD_W - 1))
                - (neg_eff ? sbmi_pkg::QUO_W'(0) : sbmi_pkg::QUO_W'(1));
      mag     = q_ff[LAST];
      res_in.vld  = vld_ff[LAST];
      res_in.sing = sing_ff[LAST];
      res_in.sat  = 1'b0;
      if (q_ff[LAST] > lim) begin
         mag        = lim;
         res_in.sat = 1'b1;
      end
      res_in.val = neg_eff ? -mag[sbmi_pkg::WORD_W-1:0] : mag[sbmi_pkg::WORD_W-1:0];
      if (sing_ff[LAST]) begin
         res_in.sat = 1'b0;
         res_in.val = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff      <= 1'b0;
         res_ff.vld <= 1'b0;
      end else if (adv) begin
         v0_ff      <= in_vld;
         res_ff.vld <= res_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff.sing <= res_in.sing;
         res_ff.sat  <= res_in.sat;
         res_ff.val  <= res_in.val;
      end
   end

   assign res = res_ff;

endmodule

[hdl/sbmi_merge.sv]
// Merge stage: combines the nine lane results and flags into one transfer, with an
// output register and a skid register. Drives the pipeline advance. Depends on sbmi_pkg.
`timescale 1ns / 1ps

module sbmi_merge (
   input  logic                         clock,
   input  logic                         reset,
   input  sbmi_pkg::lane_res_type       res[sbmi_pkg::NENT],
   output logic                         adv,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [sbmi_pkg::DATA_W-1:0]  rsp_tdata,
   output logic [sbmi_pkg::USER_W-1:0]  rsp_tuser
);

   logic                        in_vld;
   logic [sbmi_pkg::DATA_W-1:0] data_in;
   logic [sbmi_pkg::USER_W-1:0] user_in;
   logic                        out_vld_ff;
   logic [sbmi_pkg::DATA_W-1:0] out_data_ff;
   logic [sbmi_pkg::USER_W-1:0] out_user_ff;
   logic                        skid_vld_ff;
   logic [sbmi_pkg::DATA_W-1:0] skid_data_ff;
   logic [sbmi_pkg::USER_W-1:0] skid_user_ff;
   logic                        all_vld;
   logic                        any_sing;
   logic                        any_sat;

   always_comb begin
      all_vld  = 1'b1;
      any_sing = 1'b0;
      any_sat  = 1'b0;
      data_in  = '0;
      for (int o = 0; o < sbmi_pkg::NENT; o++) begin
         all_vld  = all_vld & res[o].vld;
         any_sing = any_sing | res[o].sing;
         any_sat  = any_sat | res[o].sat;
         data_in[o*sbmi_pkg::WORD_W +: sbmi_pkg::WORD_W] = res[o].val;
      end
      user_in = '0;
      user_in[sbmi_pkg::USER_SING] = any_sing;
      user_in[sbmi_pkg::USER_SAT]  = any_sat;
   end

   assign adv    = !skid_vld_ff;
   assign in_vld = adv && all_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_vld_ff && rsp_tready) begin
         if (skid_vld_ff) begin
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= in_vld;
         end
      end else if (!out_vld_ff) begin
         out_vld_ff <= in_vld;
      end else if (in_vld) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_vld_ff && rsp_tready && skid_vld_ff) begin
         out_data_ff <= skid_data_ff;
         out_user_ff <= skid_user_ff;
      end else if (!out_vld_ff || rsp_tready) begin
         out_data_ff <= data_in;
         out_user_ff <= user_in;
      end else if (in_vld) begin
         skid_data_ff <= data_in;
         skid_user_ff <= user_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

[hdl/sbmi_checker.sv]
// Port-level checks for the small block matrix inverse, bound to the top level.
// Depends on sbmi_pkg and small_block_matrix_inverse.
`timescale 1ns / 1ps

module sbmi_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [sbmi_pkg::DATA_W-1:0]  rsp_tdata,
   input logic [sbmi_pkg::USER_W-1:0]  rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp transfer changed");

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[sbmi_pkg::USER_SING] |->
         rsp_tdata == '0 && !rsp_tuser[sbmi_pkg::USER_SAT])
      else $error("singular result not zero or flagged saturated");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty output");

endmodule

bind small_block_matrix_inverse sbmi_checker u_sbmi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/sv/small_block_matrix_inverse_checker.sv]
// Checker for the small block matrix inverse: snoops the csr, req and rsp channels,
// predicts each inverse from the accepted block and compares it field by field.
// Depends on sbmi_pkg.
`timescale 1ns / 1ps

module small_block_matrix_inverse_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [sbmi_pkg::BS_W-1:0]     csr_wdata,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [sbmi_pkg::DATA_W-1:0]   req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [sbmi_pkg::DATA_W-1:0]   rsp_tdata,
   input  logic [sbmi_pkg::USER_W-1:0]   rsp_tuser,
   output int                            pending_inverses,
   output int                            error_count
);
   import sbmi_pkg::*;

   typedef logic signed [255:0] wide_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [USER_W-1:0] user;
   } inverse_type;

   inverse_type          expected_inverses[$];
   logic [BS_W-1:0]      size_reg;

   assign pending_inverses = expected_inverses.size();

   // round(cof * 2^(2F) / det) with ties away from zero, clipped to the word range
   function automatic logic [WORD_W-1:0] scaled_quotient(wide_type cof, wide_type det,
                                                         inout logic clipped);
      logic [255:0] cmag, dmag, quo, lim;
      logic         neg;
      cmag = (cof < 0) ? -cof : cof;
      dmag = (det < 0) ? -det : det;
      neg  = (cof < 0) != (det < 0);
      quo  = ((cmag << SHIFT_W) + dmag) / (dmag << 1);
      if (quo == 0) neg = 1'b0;
      lim = (256'd1 << (WORD_W - 1)) - (neg ? 256'd0 : 256'd1);
      if (quo > lim) begin
         quo = lim;
         clipped = 1'b1;
      end
      return neg ? WORD_W'(-quo) : WORD_W'(quo);
   endfunction

   function automatic inverse_type invert_block(logic [DATA_W-1:0] d, logic [BS_W-1:0] bs);
      wide_type    m[3][3];
      wide_type    cof[3][3];
      wide_type    det;
      inverse_type res;
      int          n;
      logic        clipped;
      n = (bs == BS_ZERO) ? 1 : int'(bs);
      clipped = 1'b0;
      res = '0;
      for (int c = 0; c < 3; c++)
         for (int r = 0; r < 3; r++) begin
            m[r][c] = wide_type'($signed(d[(c*3+r)*WORD_W +: WORD_W]));
            cof[r][c] = '0;
         end
      if (n == 1) begin
         cof[0][0] = 1;
         det = m[0][0];
      end else if (n == 2) begin
         cof[0][0] = m[1][1];
         cof[0][1] = -m[1][0];
         cof[1][0] = -m[0][1];
         cof[1][1] = m[0][0];
         det = m[0][0] * m[1][1] - m[0][1] * m[1][0];
      end else begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               cof[r][c] = m[(r+1)%3][(c+1)%3] * m[(r+2)%3][(c+2)%3]
                         - m[(r+1)%3][(c+2)%3] * m[(r+2)%3][(c+1)%3];
         det = 0;
         for (int c = 0; c < 3; c++) det = det + m[0][c] * cof[0][c];
      end
      if (det == 0) begin
         res.user[USER_SING] = 1'b1;
      end else begin
         for (int c = 0; c < n; c++)
            for (int r = 0; r < n; r++)
               res.data[(c*3+r)*WORD_W +: WORD_W] = scaled_quotient(cof[c][r], det, clipped);
      end
      res.user[USER_SAT] = clipped;
      return res;
   endfunction

   always @(posedge clock) begin
      inverse_type want;
      if (reset) begin
         size_reg <= BS_ONE;
         expected_inverses.delete();
         error_count <= 0;
      end else begin
         if (csr_we) size_reg <= csr_wdata;
         if (req_tvalid && req_tready) expected_inverses.push_back(invert_block(req_tdata, size_reg));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_inverses.size() == 0) begin
               $display("%0t: unexpected result, actual data %h user %b",
                        $time, rsp_tdata, rsp_tuser);
               error_count <= error_count + 1;
            end else begin
               want = expected_inverses.pop_front();
               if (want.data != rsp_tdata || want.user != rsp_tuser) begin
                  for (int k = 0; k < NENT; k++)
                     if (want.data[k*WORD_W +: WORD_W] != rsp_tdata[k*WORD_W +: WORD_W])
                        $display("%0t: entry r%0d%0d expected %h actual %h", $time,
                                 k % 3 + 1, k / 3 + 1, want.data[k*WORD_W +: WORD_W],
                                 rsp_tdata[k*WORD_W +: WORD_W]);
                  if (want.user[USER_SING] != rsp_tuser[USER_SING])
                     $display("%0t: singular expected %b actual %b", $time,
                              want.user[USER_SING], rsp_tuser[USER_SING]);
                  if (want.user[USER_SAT] != rsp_tuser[USER_SAT])
                     $display("%0t: saturated expected %b actual %b", $time,
                              want.user[USER_SAT], rsp_tuser[USER_SAT]);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

[tb/sv/small_block_matrix_inverse_tb.sv]
// Top of the small block matrix inverse testbench: clock, reset, block-size phases,
// directed and random blocks with random gaps and stalls, and the verdict.
// Depends on sbmi_pkg, small_block_matrix_inverse and small_block_matrix_inverse_checker.
`timescale 1ns / 1ps

module small_block_matrix_inverse_tb;
   import sbmi_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 60;

   logic                clock;
   logic                reset = 1'b1;
   logic                csr_we;
   logic [BS_W-1:0]     csr_wdata;
   logic                req_tvalid;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [DATA_W-1:0]   rsp_tdata;
   logic [USER_W-1:0]   rsp_tuser;
   int                  pending_inverses;
   int                  error_count;
   int                  cycle_count = 0;
   int                  stall_left = 0;
   logic                steady_phase;

   small_block_matrix_inverse dut (.*);

   small_block_matrix_inverse_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // hold ready low for random stretches, mostly short, a few long
   always @(posedge clock) begin
      if (reset || steady_phase) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (steady_phase || roll < 11) return 0;
      if (roll < 19) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_block(logic [DATA_W-1:0] block);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= block;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_inverses != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(logic [BS_W-1:0] bs);
      csr_we <= 1'b1;
      csr_wdata <= bs;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [WORD_W-1:0] random_entry();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return WORD_W'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
         2: return WORD_W'($signed($urandom_range(0, 32'h800)) - 32'sh400);
         default: return ($urandom_range(0, 1) != 0) ? 32'h00010000 : 32'hffff0000;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] random_block();
      logic [DATA_W-1:0] b;
      for (int k = 0; k < NENT; k++) b[k*WORD_W +: WORD_W] = random_entry();
      return b;
   endfunction

   function automatic logic [DATA_W-1:0] diag_block(logic [WORD_W-1:0] v);
      logic [DATA_W-1:0] b;
      b = random_block();
      for (int k = 0; k < NENT; k++) if (k % 3 != k / 3) b[k*WORD_W +: WORD_W] = '0;
      for (int k = 0; k < 3; k++) b[(k*4)*WORD_W +: WORD_W] = v;
      return b;
   endfunction

   task automatic run_phase(logic [BS_W-1:0] bs, int random_items);
      logic [DATA_W-1:0] b;
      write_size(bs);
      send_block('0);
      send_block(diag_block(32'h00010000));
      send_block(diag_block(32'h00000001));
      send_block(diag_block(32'hffffffff));
      send_block({NENT{32'h7fffffff}});
      send_block({NENT{32'h80000000}});
      b = {NENT{32'h80000000}};
      b[4*WORD_W +: WORD_W] = 32'h7fffffff;
      b[8*WORD_W +: WORD_W] = 32'h7fffffff;
      send_block(b);
      send_block({NENT{32'hffffffff}});
      for (int i = 0; i < random_items; i++) begin
         steady_phase <= (i % 40) >= 30;
         send_block((i % 5 == 0) ? diag_block(random_entry()) : random_block());
      end
      steady_phase <= 1'b0;
      drain();
   endtask

   initial begin
      csr_we = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      steady_phase = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_phase(BS_ONE, 70);
      run_phase(BS_TWO, 80);
      run_phase(BS_FULL, 110);
      run_phase(BS_ZERO, 60);
      run_phase(BS_FULL, 110);
      run_phase(BS_TWO, 80);
      run_phase(BS_ONE, 60);
      run_phase(BS_FULL, 70);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
